/* hdl/rau_pkg.sv */
// Shared types, command and status codes for the rational arithmetic unit.
package rau_pkg;

   localparam int unsigned MAG_WIDTH = 64;

   typedef enum logic [2:0] {
      CMD_NORM = 3'd0,
      CMD_ADD  = 3'd1,
      CMD_SUB  = 3'd2,
      CMD_MUL  = 3'd3,
      CMD_DIV  = 3'd4,
      CMD_CMP  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_DIV_ZERO = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      OP_LOAD_A,
      OP_LOAD_B,
      OP_LOAD_R,
      OP_GCD_STEP,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_STORE_A,
      OP_STORE_B,
      OP_STORE_R,
      OP_MUL_X,
      OP_MUL_Y,
      OP_MUL_D,
      OP_COMBINE,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] div_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic gcd_done;
      logic div_done;
      logic b_zero;
   } dp_status_type;

endpackage

/* hdl/rau_datapath.sv */
// Datapath: operand registers, shared Euclid remainder unit, serial divider, multiplier.
module rau_datapath #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic [2:0]            cmd_code,
   input  logic [DATA_WIDTH-1:0] a_num,
   input  logic [DATA_WIDTH-1:0] a_den,
   input  logic [DATA_WIDTH-1:0] b_num,
   input  logic [DATA_WIDTH-1:0] b_den,
   input  rau_pkg::dp_cmd_type   dp_cmd,
   output rau_pkg::dp_status_type dp_stat,
   output logic [31:0]           res_num,
   output logic [30:0]           res_den,
   output logic                  less_flag,
   output logic                  equal_flag,
   output logic                  ovf_flag
);
   localparam int unsigned MW = rau_pkg::MAG_WIDTH;
   localparam int unsigned CW = $clog2(MW + 1);
   localparam logic [MW-1:0] LIM = MW'(1) << (DATA_WIDTH - 1);

   logic          an_ff, bn_ff, rn_ff;
   logic [MW-1:0] am_ff, ad_ff, bm_ff, bd_ff, rm_ff, rd_ff;
   logic [MW-1:0] gx_ff, gy_ff, qm_ff, qd_ff;
   logic [MW-1:0] dn_ff, dq_ff, dr_ff;
   logic [CW-1:0] dc_ff;
   logic [MW-1:0] px_ff, py_ff, pd_ff;
   logic          xn_ff;
   logic [DATA_WIDTH-1:0] sn, sd;
   logic [MW-1:0] mag_n, mag_d, gmod, g_use, rem_sh, mul_a, mul_b, mul_p;
   logic          neg_n, neg_d, lt;
   logic [MW:0]   rem_try;

   always_comb begin
      sn = (cmd_code == 3'(rau_pkg::CMD_NORM)) ? a_num : a_num;
      sd = a_den;
      if (dp_cmd.op == rau_pkg::OP_LOAD_B) begin
         sn = b_num;
         sd = b_den;
      end
      neg_n = sn[DATA_WIDTH-1];
      neg_d = sd[DATA_WIDTH-1];
      mag_n = neg_n ? MW'(-$signed({1'b1, sn})) : MW'(sn);
      mag_d = neg_d ? MW'(-$signed({1'b1, sd})) : MW'(sd);
   end

   // one remainder bit per step over the divider registers
   always_comb begin
      rem_sh  = {dr_ff[MW-2:0], dn_ff[MW-1]};
      rem_try = {1'b0, rem_sh} - {1'b0, (dp_cmd.div_sel == 2'd2) ? gy_ff : g_use};
      if (dr_ff[MW-1]) rem_try[MW] = 1'b0;
   end

   assign g_use = (gx_ff == '0) ? MW'(1) : gx_ff;
   assign gmod  = dr_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (dp_cmd.op)
         rau_pkg::OP_MUL_X: begin mul_a = am_ff; mul_b = (cmd_code == 3'(rau_pkg::CMD_MUL)) ? bm_ff : bd_ff; end
         rau_pkg::OP_MUL_Y: begin mul_a = (cmd_code == 3'(rau_pkg::CMD_DIV) || cmd_code == 3'(rau_pkg::CMD_MUL)) ? ad_ff : bm_ff;
                                  mul_b = (cmd_code == 3'(rau_pkg::CMD_DIV)) ? bm_ff : (cmd_code == 3'(rau_pkg::CMD_MUL) ? bd_ff : ad_ff); end
         rau_pkg::OP_MUL_D: begin mul_a = ad_ff; mul_b = bd_ff; end
         default: ;
      endcase
      mul_p = MW'(mul_a[31:0] * mul_b[31:0]);
   end

   always_comb begin
      if (xn_ff != bn_ff) lt = xn_ff && (px_ff != '0 || py_ff != '0);
      else lt = xn_ff ? (px_ff > py_ff) : (px_ff < py_ff);
      if (px_ff == '0 && py_ff == '0) lt = 1'b0;
      else if (px_ff == '0) lt = !bn_ff;
      else if (py_ff == '0) lt = xn_ff;
   end

   always_ff @(posedge clock) begin
      unique case (dp_cmd.op)
         rau_pkg::OP_LOAD_A, rau_pkg::OP_LOAD_B: begin
            rn_ff <= neg_n ^ neg_d;
            rm_ff <= mag_n;
            rd_ff <= mag_d;
            gx_ff <= mag_n;
            gy_ff <= mag_d;
         end
         rau_pkg::OP_LOAD_R: begin
            gx_ff <= rm_ff;
            gy_ff <= rd_ff;
         end
         rau_pkg::OP_GCD_STEP: begin
            // gx mod gy through the serial divider, then rotate
            gx_ff <= gy_ff;
            gy_ff <= gmod;
         end
         rau_pkg::OP_DIV_INIT: begin
            dn_ff <= (dp_cmd.div_sel == 2'd2) ? gx_ff : (dp_cmd.div_sel == 2'd0 ? rm_ff : rd_ff);
            dr_ff <= '0;
            dq_ff <= '0;
            dc_ff <= CW'(MW);
         end
         rau_pkg::OP_DIV_STEP: begin
            dn_ff <= {dn_ff[MW-2:0], 1'b0};
            if (!rem_try[MW]) begin
               dr_ff <= rem_try[MW-1:0];
               dq_ff <= {dq_ff[MW-2:0], 1'b1};
            end else begin
               dr_ff <= rem_sh;
               dq_ff <= {dq_ff[MW-2:0], 1'b0};
            end
            dc_ff <= dc_ff - CW'(1);
         end
         rau_pkg::OP_STORE_A: if (dp_cmd.div_sel == 2'd0) am_ff <= dq_ff; else begin ad_ff <= dq_ff; an_ff <= rn_ff && am_ff != '0; end
         rau_pkg::OP_STORE_B: if (dp_cmd.div_sel == 2'd0) bm_ff <= dq_ff; else begin bd_ff <= dq_ff; bn_ff <= rn_ff && bm_ff != '0; end
         rau_pkg::OP_STORE_R: if (dp_cmd.div_sel == 2'd0) qm_ff <= dq_ff; else qd_ff <= dq_ff;
         rau_pkg::OP_MUL_X: begin px_ff <= mul_p; xn_ff <= an_ff; end
         rau_pkg::OP_MUL_Y: begin
            py_ff <= mul_p;
            if (cmd_code == 3'(rau_pkg::CMD_SUB)) bn_ff <= !bn_ff && bm_ff != '0;
         end
         rau_pkg::OP_MUL_D: pd_ff <= mul_p;
         rau_pkg::OP_COMBINE: begin
            rd_ff <= pd_ff;
            if (cmd_code == 3'(rau_pkg::CMD_MUL) || cmd_code == 3'(rau_pkg::CMD_DIV)) begin
               rn_ff <= an_ff ^ bn_ff;
               rm_ff <= px_ff;
               if (cmd_code == 3'(rau_pkg::CMD_DIV)) rd_ff <= py_ff;
            end else if (xn_ff == bn_ff) begin
               rn_ff <= xn_ff;
               rm_ff <= px_ff + py_ff;
            end else if (px_ff >= py_ff) begin
               rn_ff <= xn_ff;
               rm_ff <= px_ff - py_ff;
            end else begin
               rn_ff <= bn_ff;
               rm_ff <= py_ff - px_ff;
            end
         end
         default: ;
      endcase
   end

   logic rneg;
   assign rneg = rn_ff && qm_ff != '0;
   assign dp_stat.gcd_done = (gy_ff == '0);
   assign dp_stat.div_done = (dc_ff == '0);
   assign dp_stat.b_zero   = (bm_ff == '0);
   assign ovf_flag   = (qd_ff > LIM - MW'(1)) || (qm_ff > (rneg ? LIM : LIM - MW'(1)));
   assign res_num    = rneg ? 32'(-qm_ff) : qm_ff[31:0];
   assign res_den    = qd_ff[30:0];
   assign less_flag  = lt;
   assign equal_flag = (an_ff == bn_ff) && (am_ff == bm_ff) && (ad_ff == bd_ff);
endmodule

/* hdl/rau_controller.sv */
// Controller: sequences loading, gcd reduction, products and result reduction.
module rau_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [2:0]             cmd_code,
   input  logic                   a_den_zero,
   input  logic                   b_den_zero,
   input  rau_pkg::dp_status_type dp_stat,
   input  logic                   ovf_flag,
   input  logic                   out_free,
   output rau_pkg::dp_cmd_type    dp_cmd,
   output logic                   busy,
   output logic                   done,
   output logic [1:0]             status,
   output logic                   res_valid,
   output logic                   cmp_mode
);
   typedef enum logic [3:0] {
      S_IDLE, S_GCD, S_GDIV, S_QDIV, S_STORE, S_MULX, S_MULY, S_MULD,
      S_COMB, S_LOADR, S_FINISH
   } state_type;

   state_type  state_ff;
   logic [1:0] phase_ff;   // 0 operand a, 1 operand b, 2 result
   logic [1:0] part_ff;    // 0 numerator, 1 denominator
   logic [1:0] status_ff;
   logic       done_ff, rv_ff, cmp_ff;

   always_comb begin
      dp_cmd.op = rau_pkg::OP_NONE;
      dp_cmd.div_sel = part_ff;
      unique case (state_ff)
         S_IDLE:  if (start) dp_cmd.op = rau_pkg::OP_LOAD_A;
         S_GCD:   if (!dp_stat.gcd_done) begin dp_cmd.op = rau_pkg::OP_DIV_INIT; dp_cmd.div_sel = 2'd2; end
                  else begin dp_cmd.op = rau_pkg::OP_DIV_INIT; end
         S_GDIV:  begin dp_cmd.div_sel = 2'd2; dp_cmd.op = dp_stat.div_done ? rau_pkg::OP_GCD_STEP : rau_pkg::OP_DIV_STEP; end
         S_QDIV:  if (!dp_stat.div_done) dp_cmd.op = rau_pkg::OP_DIV_STEP;
                  else dp_cmd.op = (phase_ff == 2'd0) ? rau_pkg::OP_STORE_A :
                                   (phase_ff == 2'd1) ? rau_pkg::OP_STORE_B : rau_pkg::OP_STORE_R;
         S_STORE: if (part_ff == 2'd1 && phase_ff == 2'd0 && cmd_code != 3'(rau_pkg::CMD_NORM))
                     dp_cmd.op = rau_pkg::OP_LOAD_B;
         S_MULX:  dp_cmd.op = rau_pkg::OP_MUL_X;
         S_MULY:  dp_cmd.op = rau_pkg::OP_MUL_Y;
         S_MULD:  dp_cmd.op = rau_pkg::OP_MUL_D;
         S_COMB:  dp_cmd.op = rau_pkg::OP_COMBINE;
         S_LOADR: dp_cmd.op = rau_pkg::OP_LOAD_R;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; phase_ff <= '0; part_ff <= '0;
         status_ff <= 2'(rau_pkg::ST_OK); done_ff <= 1'b0; rv_ff <= 1'b0; cmp_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (start) begin
               phase_ff <= 2'd0; part_ff <= 2'd0; rv_ff <= 1'b0; cmp_ff <= 1'b0;
               status_ff <= 2'(rau_pkg::ST_OK);
               if (cmd_code > 3'(rau_pkg::CMD_CMP)) state_ff <= S_FINISH;
               else if (a_den_zero || (cmd_code != 3'(rau_pkg::CMD_NORM) && b_den_zero)) begin
                  status_ff <= 2'(rau_pkg::ST_ZERO_DEN); state_ff <= S_FINISH;
               end else state_ff <= S_GCD;
            end
            S_GCD:  state_ff <= dp_stat.gcd_done ? S_QDIV : S_GDIV;
            S_GDIV: if (dp_stat.div_done) state_ff <= S_GCD;
            S_QDIV: if (dp_stat.div_done) state_ff <= S_STORE;
            S_STORE: begin
               if (part_ff == 2'd0) begin part_ff <= 2'd1; state_ff <= S_GCD; end
               else begin
                  part_ff <= 2'd0;
                  if (phase_ff == 2'd0 && cmd_code != 3'(rau_pkg::CMD_NORM)) begin
                     phase_ff <= 2'd1; state_ff <= S_GCD;
                  end else if (phase_ff == 2'd0) begin
                     phase_ff <= 2'd2; state_ff <= S_LOADR;
                  end else if (phase_ff == 2'd1) begin
                     if (cmd_code == 3'(rau_pkg::CMD_DIV) && dp_stat.b_zero) begin
                        status_ff <= 2'(rau_pkg::ST_DIV_ZERO); state_ff <= S_FINISH;
                     end else state_ff <= S_MULX;
                  end else begin
                     rv_ff <= !ovf_flag;
                     if (ovf_flag) status_ff <= 2'(rau_pkg::ST_OVERFLOW);
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_MULX: state_ff <= S_MULY;
            S_MULY: state_ff <= S_MULD;
            S_MULD: if (cmd_code == 3'(rau_pkg::CMD_CMP)) begin
               cmp_ff <= 1'b1; state_ff <= S_FINISH;
            end else state_ff <= S_COMB;
            S_COMB:  begin phase_ff <= 2'd2; state_ff <= S_LOADR; end
            S_LOADR: state_ff <= S_GCD;
            S_FINISH: if (out_free) begin done_ff <= 1'b1; state_ff <= S_IDLE; end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign done      = done_ff;
   assign status    = status_ff;
   assign res_valid = rv_ff;
   assign cmp_mode  = cmp_ff;
endmodule

/* hdl/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit: stream ports, output register, checks.
//  channel | dir | tdata fields (low bit up)                          | tuser
//  req     | in  | command[2:0] a_num b_num... see port                | -
//  rsp     | out | res_num res_den less_flag equal_flag status         | -
// One item at a time. Each Euclid step runs an init, the divider steps and a rotate,
// and each reduced fraction adds two quotient divisions, numerator and denominator.
// Operand a is reduced, then operand b unless the command is a normalize, then the
// result unless it is a compare or a division by zero; a zero denominator ends the
// item before any reduction. A finished result waits in the output register while
// the next item is accepted; a stalled rsp holds its beat and holds the next result
// in the controller. Reset is synchronous and clears control.
module rational_arithmetic_unit #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], pad
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // res_num[31:0], res_den[62:32], less_flag[63], equal_flag[64], status[66:65], pad
   output logic [71:0]  rsp_tdata
);
   logic [135:0] req_ff;
   logic         start, busy, done, res_valid, cmp_mode, ovf_flag, less_flag, equal_flag;
   logic [1:0]   status;
   logic [31:0]  res_num;
   logic [30:0]  res_den;
   logic [71:0]  rsp_data_ff;
   logic         rsp_valid_ff, out_free;
   rau_pkg::dp_cmd_type    dp_cmd;
   rau_pkg::dp_status_type dp_stat;
   logic [DATA_WIDTH-1:0]  a_num, a_den, b_num, b_den;

   assign req_tready = !busy;
   assign start      = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (start) req_ff <= req_tdata;
   end

   always_comb begin
      a_num = DATA_WIDTH'(req_ff[34:3]);
      a_den = DATA_WIDTH'(req_ff[66:35]);
      b_num = DATA_WIDTH'(req_ff[98:67]);
      b_den = DATA_WIDTH'(req_ff[130:99]);
      if (start) begin
         a_num = DATA_WIDTH'(req_tdata[34:3]);
         a_den = DATA_WIDTH'(req_tdata[66:35]);
         b_num = DATA_WIDTH'(req_tdata[98:67]);
         b_den = DATA_WIDTH'(req_tdata[130:99]);
      end
   end

   rau_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock, .cmd_code(start ? req_tdata[2:0] : req_ff[2:0]),
      .a_num, .a_den, .b_num, .b_den, .dp_cmd, .dp_stat,
      .res_num, .res_den, .less_flag, .equal_flag, .ovf_flag
   );

   rau_controller u_ctl (
      .clock, .reset, .start, .cmd_code(start ? req_tdata[2:0] : req_ff[2:0]),
      .a_den_zero(a_den == '0), .b_den_zero(b_den == '0),
      .dp_stat, .ovf_flag, .out_free, .dp_cmd, .busy, .done,
      .status, .res_valid, .cmp_mode
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (done) rsp_valid_ff <= 1'b1;
         else if (rsp_tvalid && rsp_tready) rsp_valid_ff <= 1'b0;
      end
      if (done) begin
         rsp_data_ff <= {5'd0, status,
                         cmp_mode && equal_flag, cmp_mode && less_flag,
                         res_valid ? res_den : 31'd1,
                         res_valid ? res_num : 32'd0};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("accept while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(busy)) else $error("done without work");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      done && status != 2'(rau_pkg::ST_OK) |=> rsp_tdata[31:0] == 32'd0)
      else $error("error result not cleared");
`endif
endmodule
